>>> rtl/sbrc_pkg.sv
// Shared types, constants and helpers for the scaled blit rectangle clipper.
`default_nettype none

package sbrc_pkg;

	localparam int COORD_BITS  = 16;
	localparam int WIDE_BITS   = COORD_BITS + 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [WIDE_BITS-1:0]  wide_t;
	typedef logic        [COORD_BITS-1:0] mag_t;
	typedef logic        [COORD_BITS-2:0] size_t;
	typedef logic        [1:0]            cfg_idx_t;

	localparam cfg_idx_t CFG_TILE_X      = 2'd0;
	localparam cfg_idx_t CFG_TILE_Y      = 2'd1;
	localparam cfg_idx_t CFG_TILE_WIDTH  = 2'd2;
	localparam cfg_idx_t CFG_TILE_HEIGHT = 2'd3;

	typedef struct packed {
		coord_t src_left;
		coord_t src_top;
		coord_t src_right;
		coord_t src_bottom;
		coord_t dst_left;
		coord_t dst_top;
		coord_t dst_right;
		coord_t dst_bottom;
	} in_t;

	typedef struct packed {
		logic   hit;
		coord_t local_left;
		coord_t local_top;
		coord_t local_right;
		coord_t local_bottom;
		coord_t scaled_left;
		coord_t scaled_top;
		coord_t scaled_right;
		coord_t scaled_bottom;
	} out_t;

	typedef struct packed {
		coord_t tile_x;
		coord_t tile_y;
		size_t  tile_width;
		size_t  tile_height;
	} tile_cfg_t;

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic   hit;
		coord_t loc_left;
		coord_t loc_top;
		coord_t loc_right;
		coord_t loc_bottom;
		coord_t base_x;
		coord_t base_y;
		logic   neg_x;
		logic   neg_y;
		mag_t   mag_x;
		mag_t   mag_y;
		mag_t   den_x;
		mag_t   den_y;
		mag_t   num_l;
		mag_t   num_r;
		mag_t   num_t;
		mag_t   num_b;
	} cmd_t;

	function automatic coord_t sat_coord(input wide_t v);
		logic [WIDE_BITS-COORD_BITS:0] top;
		top = v[WIDE_BITS-1:COORD_BITS-1];
		if (top == '0 || top == '1) begin
			sat_coord = v[COORD_BITS-1:0];
		end else if (v[WIDE_BITS-1]) begin
			sat_coord = {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			sat_coord = {1'b0, {(COORD_BITS-1){1'b1}}};
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/scaled_blit_rect_clipper_unit.sv
// Top level of the scaled blit rectangle clipper: config registers and part wiring.
// Path: an accepted request passes the front stage, the queue, the multiply stage,
//   16 divider stages and the output register, which gives its result beat.
// Throughput: one request per cycle while nothing stalls; the divider is fully pipelined, one bit a stage.
// Stalls: the output register freezes the back pipeline; the 4-entry queue absorbs
//   front traffic until full, then input stalls.
// Reset: arst_n clears all valid flags, queue pointers and tile registers to zero.
`default_nettype none

module scaled_blit_rect_clipper_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire sbrc_pkg::cfg_idx_t cfg_index,
	input  wire sbrc_pkg::coord_t   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire sbrc_pkg::in_t      in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output sbrc_pkg::out_t          out_data
);

	sbrc_pkg::tile_cfg_t tile_q;
	sbrc_pkg::cmd_t      front_cmd;
	sbrc_pkg::cmd_t      q_data;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;

	// Tile window registers; the user must write them only while the block is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbrc_pkg::CFG_TILE_X:      tile_q.tile_x      <= cfg_data;
				sbrc_pkg::CFG_TILE_Y:      tile_q.tile_y      <= cfg_data;
				sbrc_pkg::CFG_TILE_WIDTH:  tile_q.tile_width  <=
					cfg_data[sbrc_pkg::COORD_BITS-2:0];
				sbrc_pkg::CFG_TILE_HEIGHT: tile_q.tile_height <=
					cfg_data[sbrc_pkg::COORD_BITS-2:0];
			endcase
		end
	end

	// Classify each beat and hand it to the queue.
	sbrc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.tile     (tile_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.cmd      (front_cmd)
	);

	// Decouple front from back so each can stall on its own.
	sbrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_cmd),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	// Scale the destination edges and deliver the result beat.
	sbrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> rtl/sbrc_front.sv
// Front stage: hit test, clipping and divider operand preparation.
`default_nettype none

module sbrc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire sbrc_pkg::tile_cfg_t tile,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sbrc_pkg::in_t       in_data,
	input  wire logic                q_full,
	output logic                     push,
	output sbrc_pkg::cmd_t           cmd
);

	function automatic sbrc_pkg::mag_t abs_mag(input sbrc_pkg::wide_t v);
		sbrc_pkg::wide_t n;
		n = -v;
		abs_mag = v[sbrc_pkg::WIDE_BITS-1] ? n[sbrc_pkg::COORD_BITS-1:0]
		                                   : v[sbrc_pkg::COORD_BITS-1:0];
	endfunction

	// Flip the numerator with a negative span, then clamp it to [0, d].
	function automatic sbrc_pkg::mag_t num_clamp(input sbrc_pkg::wide_t num,
	                                             input sbrc_pkg::wide_t den,
	                                             input sbrc_pkg::mag_t d);
		sbrc_pkg::wide_t n;
		n = den[sbrc_pkg::WIDE_BITS-1] ? -num : num;
		if (n[sbrc_pkg::WIDE_BITS-1]) begin
			num_clamp = '0;
		end else if (n > sbrc_pkg::wide_t'({1'b0, d})) begin
			num_clamp = d;
		end else begin
			num_clamp = n[sbrc_pkg::COORD_BITS-1:0];
		end
	endfunction

	sbrc_pkg::wide_t x1, y1, x2, y2, dx1, dy1, dx2, dy2;
	sbrc_pkg::wide_t tx, ty, tr, tb, w1, h1, vx, vy, w, h, ll, lt;
	sbrc_pkg::mag_t  den_x, den_y;
	sbrc_pkg::cmd_t  c;
	sbrc_pkg::cmd_t  cmd_s1;
	logic            valid_s1;

	always_comb begin
		x1  = sbrc_pkg::wide_t'(in_data.src_left);
		y1  = sbrc_pkg::wide_t'(in_data.src_top);
		x2  = sbrc_pkg::wide_t'(in_data.src_right);
		y2  = sbrc_pkg::wide_t'(in_data.src_bottom);
		dx1 = sbrc_pkg::wide_t'(in_data.dst_left);
		dy1 = sbrc_pkg::wide_t'(in_data.dst_top);
		dx2 = sbrc_pkg::wide_t'(in_data.dst_right);
		dy2 = sbrc_pkg::wide_t'(in_data.dst_bottom);
		tx  = sbrc_pkg::wide_t'(tile.tile_x);
		ty  = sbrc_pkg::wide_t'(tile.tile_y);
		tr  = tx + sbrc_pkg::wide_t'(tile.tile_width);
		tb  = ty + sbrc_pkg::wide_t'(tile.tile_height);
		w1  = x2 - x1;
		h1  = y2 - y1;
		vx  = (x1 > tx) ? x1 : tx;
		vy  = (y1 > ty) ? y1 : ty;
		w   = ((x2 < tr) ? x2 : tr) - vx;
		h   = ((y2 < tb) ? y2 : tb) - vy;
		ll  = vx - tx;
		lt  = vy - ty;
		den_x = abs_mag(w1);
		den_y = abs_mag(h1);

		c.hit        = (w1 != '0) && (h1 != '0) && (x2 >= tx) && (x1 < tr)
		               && (y2 >= ty) && (y1 < tb);
		c.loc_left   = sbrc_pkg::sat_coord(ll);
		c.loc_top    = sbrc_pkg::sat_coord(lt);
		c.loc_right  = sbrc_pkg::sat_coord(ll + w);
		c.loc_bottom = sbrc_pkg::sat_coord(lt + h);
		c.base_x     = in_data.dst_left;
		c.base_y     = in_data.dst_top;
		c.neg_x      = (dx2 < dx1);
		c.neg_y      = (dy2 < dy1);
		c.mag_x      = abs_mag(dx2 - dx1);
		c.mag_y      = abs_mag(dy2 - dy1);
		c.den_x      = den_x;
		c.den_y      = den_y;
		c.num_l      = num_clamp(vx - x1, w1, den_x);
		c.num_r      = num_clamp(w, w1, den_x);
		c.num_t      = num_clamp(vy - y1, h1, den_y);
		c.num_b      = num_clamp(h, h1, den_y);
	end

	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= c;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sbrc_queue.sv
// Short command queue between front and back.
`default_nettype none

module sbrc_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sbrc_pkg::cmd_t push_data,
	output logic                full,
	input  wire logic           pop,
	output sbrc_pkg::cmd_t      pop_data,
	output logic                empty
);

	sbrc_pkg::cmd_t                  mem_q [sbrc_pkg::QUEUE_DEPTH];
	logic [sbrc_pkg::QUEUE_AW-1:0]   wr_q, rd_q;
	logic [sbrc_pkg::QUEUE_AW:0]     count_q;

	assign full     = (count_q == (sbrc_pkg::QUEUE_AW+1)'(sbrc_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (sbrc_pkg::QUEUE_AW+1)'(sbrc_pkg::QUEUE_DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not advance on push");

endmodule

`default_nettype wire

>>> rtl/sbrc_back.sv
// Back part: multiply, pipelined restoring divide, rounding and output register.
`default_nettype none

module sbrc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire sbrc_pkg::cmd_t q_data,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output sbrc_pkg::out_t      out_data
);

	localparam int CB = sbrc_pkg::COORD_BITS;

	typedef logic [2*CB-1:0] prod_t;

	typedef struct packed {
		sbrc_pkg::cmd_t c;
		prod_t [3:0]    prod;
	} mul_t;

	typedef struct packed {
		sbrc_pkg::cmd_t        c;
		sbrc_pkg::mag_t [3:0]  rem;
		sbrc_pkg::mag_t [3:0]  sh;
	} div_t;

	// base + (+/-)(q + r/d), rounded half away from zero.
	function automatic sbrc_pkg::wide_t scale_fix(input sbrc_pkg::wide_t base,
	                                              input logic neg,
	                                              input sbrc_pkg::mag_t q,
	                                              input sbrc_pkg::mag_t r,
	                                              input sbrc_pkg::mag_t d);
		sbrc_pkg::wide_t ip;
		sbrc_pkg::mag_t  f;
		logic [CB:0]     twof;
		logic [CB:0]     dd;
		logic            inc;
		if (!neg) begin
			ip = base + sbrc_pkg::wide_t'(q);
			f  = r;
		end else if (r == '0) begin
			ip = base - sbrc_pkg::wide_t'(q);
			f  = '0;
		end else begin
			ip = base - sbrc_pkg::wide_t'(q) - sbrc_pkg::wide_t'(1);
			f  = d - r;
		end
		twof = {f, 1'b0};
		dd   = {1'b0, d};
		inc  = ip[sbrc_pkg::WIDE_BITS-1] ? (twof > dd) : (twof >= dd);
		scale_fix = ip + sbrc_pkg::wide_t'(inc);
	endfunction

	logic            en;
	mul_t            mul_s1;
	logic            mul_v_s1;
	div_t            div_s2   [CB];
	logic [CB-1:0]   div_v_s2;
	div_t            div_nx   [CB];
	div_t            init;
	mul_t            mul_nx;
	sbrc_pkg::out_t  res;
	sbrc_pkg::out_t  out_q;
	logic            out_v_q;
	sbrc_pkg::wide_t nl, nr, nt, nb;

	assign en        = !out_v_q || !out_stall;
	assign pop       = en && !q_empty;
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_comb begin
		mul_nx.c       = q_data;
		mul_nx.prod[0] = prod_t'(q_data.mag_x) * prod_t'(q_data.num_l);
		mul_nx.prod[1] = prod_t'(q_data.mag_x) * prod_t'(q_data.num_r);
		mul_nx.prod[2] = prod_t'(q_data.mag_y) * prod_t'(q_data.num_t);
		mul_nx.prod[3] = prod_t'(q_data.mag_y) * prod_t'(q_data.num_b);
	end

	// One quotient bit per stage; the top half of each product is already below d for nonzero d.
	always_comb begin
		div_t           src;
		logic [CB:0]    t;
		sbrc_pkg::mag_t d;
		init.c = mul_s1.c;
		for (int i = 0; i < 4; i++) begin
			init.rem[i] = mul_s1.prod[i][2*CB-1:CB];
			init.sh[i]  = mul_s1.prod[i][CB-1:0];
		end
		for (int k = 0; k < CB; k++) begin
			src = (k == 0) ? init : div_s2[(k == 0) ? 0 : k-1];
			div_nx[k].c = src.c;
			for (int i = 0; i < 4; i++) begin
				d = (i < 2) ? src.c.den_x : src.c.den_y;
				t = {src.rem[i], src.sh[i][CB-1]};
				if (t >= {1'b0, d}) begin
					div_nx[k].rem[i] = sbrc_pkg::mag_t'(t - {1'b0, d});
					div_nx[k].sh[i]  = {src.sh[i][CB-2:0], 1'b1};
				end else begin
					div_nx[k].rem[i] = t[CB-1:0];
					div_nx[k].sh[i]  = {src.sh[i][CB-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		div_t fin;
		fin = div_s2[CB-1];
		nl  = scale_fix(sbrc_pkg::wide_t'(fin.c.base_x), fin.c.neg_x,
		                fin.sh[0], fin.rem[0], fin.c.den_x);
		nr  = scale_fix(nl, fin.c.neg_x, fin.sh[1], fin.rem[1], fin.c.den_x);
		nt  = scale_fix(sbrc_pkg::wide_t'(fin.c.base_y), fin.c.neg_y,
		                fin.sh[2], fin.rem[2], fin.c.den_y);
		nb  = scale_fix(nt, fin.c.neg_y, fin.sh[3], fin.rem[3], fin.c.den_y);
		res = '0;
		if (fin.c.hit) begin
			res.hit           = 1'b1;
			res.local_left    = fin.c.loc_left;
			res.local_top     = fin.c.loc_top;
			res.local_right   = fin.c.loc_right;
			res.local_bottom  = fin.c.loc_bottom;
			res.scaled_left   = sbrc_pkg::sat_coord(nl);
			res.scaled_top    = sbrc_pkg::sat_coord(nt);
			res.scaled_right  = sbrc_pkg::sat_coord(nr);
			res.scaled_bottom = sbrc_pkg::sat_coord(nb);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_v_s1 <= 1'b0;
			div_v_s2 <= '0;
			out_v_q  <= 1'b0;
		end else if (en) begin
			mul_v_s1 <= pop;
			div_v_s2 <= {div_v_s2[CB-2:0], mul_v_s1};
			out_v_q  <= div_v_s2[CB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mul_s1 <= mul_nx;
			for (int k = 0; k < CB; k++) begin
				div_s2[k] <= div_nx[k];
			end
			out_q <= res;
		end
	end

endmodule

`default_nettype wire
